// ===== src/mm4_pkg.sv =====
// ----------------------------------------------------------------------------
// mm4_pkg
// Types and constants shared by the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;
  // four products need two guard bits
  localparam int unsigned AccW     = ProdW + 2;

  typedef enum logic [2:0] {
    OP_WRITE_L = 3'd0,
    OP_WRITE_R = 3'd1,
    OP_IDENT   = 3'd2,
    OP_READ    = 3'd3,
    OP_MUL     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IDENT,
    ST_READ,
    ST_MUL
  } state_e;

  // travels with each memory read down the pipeline
  typedef struct packed {
    logic       v;
    logic       rd;
    logic       first;
    logic       lastk;
    logic       olast;
    logic [1:0] row;
    logic [1:0] col;
  } tag_t;

  typedef struct packed {
    logic              wr_l;
    logic              wr_r;
    logic [3:0]        waddr;
    logic [DataW-1:0]  wdata;
    logic [3:0]        addr_l;
    logic [3:0]        addr_r;
    tag_t              tag;
  } issue_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== src/mm4_in_if.sv =====
// ----------------------------------------------------------------------------
// mm4_in_if
// Command channel: opcode, element index and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm4_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] value;

  modport source (output valid, opcode, row, col, value, input ready);
  modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

`default_nettype wire

// ===== src/mm4_out_if.sv =====
// ----------------------------------------------------------------------------
// mm4_out_if
// Result channel: element position, value and end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm4_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_row;
  logic [1:0]         out_col;
  logic signed [31:0] out_value;
  logic               last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

`default_nettype wire

// ===== src/mm4_seq.sv =====
// ----------------------------------------------------------------------------
// mm4_seq
// Command sequencer: takes commands, sweeps the identity load and issues
// memory reads for element reads and for the multiply-accumulate runs.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_seq
  import mm4_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [1:0]  row_i,
  input  wire logic [1:0]  col_i,
  input  wire logic [31:0] value_i,
  input  wire status_t     status_i,
  output issue_t           issue_o
);

  localparam logic [DataW-1:0] IdentOne =
      (FracBits >= DataW - 1) ? {1'b0, {(DataW-1){1'b1}}} : DataW'(1) << FracBits;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d;
  logic [1:0] rrow_q, rrow_d;
  logic [1:0] rcol_q, rcol_d;
  logic       accept;
  logic       can_start;

  assign accept    = valid_i && ready_o;
  assign can_start = !status_i.pipe_busy && !status_i.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      rrow_q  <= '0;
      rcol_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      rrow_q  <= rrow_d;
      rcol_q  <= rcol_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          case (op_e'(opcode_i))
            OP_IDENT: state_d = ST_IDENT;
            OP_READ:  state_d = ST_READ;
            OP_MUL:   state_d = ST_MUL;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_IDENT: if (cnt_q == 4'd15) state_d = ST_IDLE;
      ST_READ:  if (can_start) state_d = ST_IDLE;
      ST_MUL: begin
        if (k_q == 2'd3 && cnt_q == 4'd15) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    ready_o = 1'b0;
    cnt_d   = cnt_q;
    k_d     = k_q;
    rrow_d  = rrow_q;
    rcol_d  = rcol_q;
    issue_o = '0;
    case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        cnt_d   = '0;
        k_d     = '0;
        if (accept) begin
          rrow_d = row_i;
          rcol_d = col_i;
        end
        issue_o.waddr = {row_i, col_i};
        issue_o.wdata = value_i;
        issue_o.wr_l  = accept && (op_e'(opcode_i) == OP_WRITE_L);
        issue_o.wr_r  = accept && (op_e'(opcode_i) == OP_WRITE_R);
      end
      ST_IDENT: begin
        issue_o.wr_l  = 1'b1;
        issue_o.waddr = cnt_q;
        issue_o.wdata = (cnt_q[3:2] == cnt_q[1:0]) ? IdentOne : '0;
        cnt_d         = cnt_q + 4'd1;
      end
      ST_READ: begin
        issue_o.addr_l    = {rrow_q, rcol_q};
        issue_o.tag.v     = can_start;
        issue_o.tag.rd    = 1'b1;
        issue_o.tag.olast = 1'b1;
        issue_o.tag.row   = rrow_q;
        issue_o.tag.col   = rcol_q;
      end
      ST_MUL: begin
        issue_o.addr_l    = {cnt_q[3:2], k_q};
        issue_o.addr_r    = {k_q, cnt_q[1:0]};
        issue_o.tag.first = (k_q == 2'd0);
        issue_o.tag.lastk = (k_q == 2'd3);
        issue_o.tag.olast = (cnt_q == 4'd15);
        issue_o.tag.row   = cnt_q[3:2];
        issue_o.tag.col   = cnt_q[1:0];
        // an element starts only into an empty pipeline and a free output
        issue_o.tag.v     = (k_q != 2'd0) || can_start;
        if (issue_o.tag.v) begin
          k_d = k_q + 2'd1;
          if (k_q == 2'd3) cnt_d = cnt_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  a_ident_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDENT && cnt_q == 4'd15 |=> state_q == ST_IDLE)
    else $error("identity sweep overran");

  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_o.tag.v && (issue_o.tag.first || issue_o.tag.rd) |->
      !status_i.pipe_busy && !status_i.out_busy)
    else $error("element started while pipeline or output busy");

endmodule

`default_nettype wire

// ===== src/mm4_dp.sv =====
// ----------------------------------------------------------------------------
// mm4_dp
// Matrix memories, multiply-accumulate pipeline, scaling with saturation
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_dp
  import mm4_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire issue_t issue_i,
  output status_t     status_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [1:0]  out_row_o,
  output logic [1:0]  out_col_o,
  output logic [31:0] out_value_o,
  output logic        out_last_o
);

  logic [DataW-1:0] left_mem  [16];
  logic [DataW-1:0] right_mem [16];

  logic signed [DataW-1:0] rdl_q, rdr_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_d, acc_q, scaled;
  tag_t                    s1_q, s2_q, s3_q;
  tag_t                    s2_d, s3_d;

  logic                    res_v;
  logic [DataW-1:0]        res_value, sat_value;
  tag_t                    res_tag;
  logic                    out_valid_q;
  logic [1:0]              out_row_q, out_col_q;
  logic [DataW-1:0]        out_value_q;
  logic                    out_last_q;

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (issue_i.wr_l) left_mem[issue_i.waddr] <= issue_i.wdata;
    if (issue_i.tag.v) rdl_q <= left_mem[issue_i.addr_l];
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.wr_r) right_mem[issue_i.waddr] <= issue_i.wdata;
    if (issue_i.tag.v) rdr_q <= right_mem[issue_i.addr_r];
  end

  assign prod_d = rdl_q * rdr_q;
  assign acc_d  = s2_q.first ? AccW'(prod_q) : acc_q + AccW'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_q.v) acc_q <= acc_d;
  end

  // reads leave after stage one, only the last product of an element goes on
  always_comb begin
    s2_d   = s1_q;
    s2_d.v = s1_q.v && !s1_q.rd;
    s3_d   = s2_q;
    s3_d.v = s2_q.v && s2_q.lastk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= issue_i.tag;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  // floor scaling, then clamp to the 32-bit range
  assign scaled = acc_q >>> FracBits;
  always_comb begin
    if (scaled[AccW-1:DataW-1] == '0 || scaled[AccW-1:DataW-1] == '1) begin
      sat_value = scaled[DataW-1:0];
    end else if (scaled[AccW-1]) begin
      sat_value = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  always_comb begin
    if (s1_q.v && s1_q.rd) begin
      res_v     = 1'b1;
      res_tag   = s1_q;
      res_value = rdl_q;
    end else begin
      res_v     = s3_q.v;
      res_tag   = s3_q;
      res_value = sat_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_v) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v) begin
      out_row_q   <= res_tag.row;
      out_col_q   <= res_tag.col;
      out_value_q <= res_value;
      out_last_q  <= res_tag.olast;
    end
  end

  assign status_o.pipe_busy = s1_q.v || s2_q.v || s3_q.v;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v |-> !out_valid_q || out_ready_i)
    else $error("result overwrote a beat not yet taken");

  a_one_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_q.v |-> !s1_q.v && !s2_q.v)
    else $error("two elements in flight");

  a_acc_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q.v && !s2_q.first |-> $past(s2_q.v))
    else $error("accumulate without a preceding product");

endmodule

`default_nettype wire

// ===== src/matrix_multiply_4x4.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// 4x4 signed Q16.16 matrix store and multiplier with element read-back.
// ----------------------------------------------------------------------------
// Holds a left and a right 4x4 matrix in two 16-entry memories. A write
// beat writes one element; an identity load sweeps the left memory; a
// read returns one beat. A multiply emits 16 beats in row-major order,
// last set on row 3 col 3: each element needs four reads through the
// single read port of each memory, four 32x32 products and a 66-bit
// accumulate, and the next element starts once the previous one has
// drained. Sums are floored by 2^16 and clamped to the 32-bit range.
// Matrix contents are undefined until written. New commands are taken
// only between operations.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_4x4
  import mm4_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mm4_in_if.sink     in_i,
  mm4_out_if.source  out_o
);

  issue_t  issue;
  status_t status;

  mm4_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .opcode_i (in_i.opcode),
    .row_i    (in_i.row),
    .col_i    (in_i.col),
    .value_i  (in_i.value),
    .status_i (status),
    .issue_o  (issue)
  );

  mm4_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .out_value_o (out_o.out_value),
    .out_last_o  (out_o.last)
  );

endmodule

`default_nettype wire
